@@ hw/rtl/ultrasonic_echo_ranger_unit_defines.svh @@
// assertion macros for the echo ranger
`ifndef ULTRASONIC_ECHO_RANGER_UNIT_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_UNIT_DEFINES_SVH

// same-cycle implication, checked on clk_i, off while in reset
`define EUR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk_i, off while in reset
`define EUR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/eur_pkg.sv @@
// shared types, constants and the distance function of the echo ranger
package eur_pkg;

  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned DistW    = 12;
  localparam int unsigned CntW     = 16;
  localparam int unsigned TrigW    = 8;

  // reset values of the registers
  localparam logic [TrigW-1:0] TriggerTicksRst = 8'd10;
  localparam logic [CntW-1:0]  WaitLimitRst    = 16'd30000;
  localparam logic [CntW-1:0]  WidthLimitRst   = 16'd30000;

  // width*3/58 == ((width*3) >> 1) / 29, and y/29 == (y * ceil(2^21/29)) >> 21
  // for every y below 2^17 (error term 12*y stays under 2^21)
  localparam logic [16:0] DistRecip = 17'd72316;
  localparam int unsigned DistShift = 21;

  typedef enum logic [1:0] {
    REG_TRIGGER_TICKS = 2'd0,
    REG_WAIT_LIMIT    = 2'd1,
    REG_WIDTH_LIMIT   = 2'd2
  } eur_reg_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TRIG = 2'd1,
    PH_WAIT = 2'd2,
    PH_MEAS = 2'd3
  } eur_phase_e;

  typedef struct packed {
    logic [TrigW-1:0] trigger_ticks;
    logic [CntW-1:0]  wait_limit;
    logic [CntW-1:0]  width_limit;
  } eur_cfg_t;

  typedef struct packed {
    logic             trigger_level;
    logic             done_res;
    logic             no_echo;
    logic [DistW-1:0] distance_cm;
  } eur_res_t;

  function automatic logic [DistW-1:0] eur_distance(input logic [CntW-1:0] width);
    logic [17:0] triple;
    logic [16:0] half;
    logic [33:0] prod;
    triple = {2'b00, width} + {1'b0, width, 1'b0};
    half   = triple[17:1];
    prod   = 34'(half) * 34'(DistRecip);
    return prod[DistShift+DistW-1:DistShift];
  endfunction

endpackage

@@ hw/rtl/eur_in_if.sv @@
// input channel: one tick item with start request and echo sample
interface eur_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo_level;

  modport source(output valid, output start_req, output echo_level, input ready);
  modport sink(input valid, input start_req, input echo_level, output ready);
endinterface

@@ hw/rtl/eur_out_if.sv @@
// output channel: one result item per tick
interface eur_out_if;
  import eur_pkg::*;

  logic             valid;
  logic             ready;
  logic             trigger_level;
  logic             done_res;
  logic             no_echo;
  logic [DistW-1:0] distance_cm;

  modport source(output valid, output trigger_level, output done_res, output no_echo,
                 output distance_cm, input ready);
  modport sink(input valid, input trigger_level, input done_res, input no_echo,
               input distance_cm, output ready);
endinterface

@@ hw/rtl/eur_apb_regs.sv @@
// apb register file holding the three ranger settings
module eur_apb_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [eur_pkg::ApbAddrW-1:0]  paddr,
  input  logic [eur_pkg::ApbDataW-1:0]  pwdata,
  output logic [eur_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  output eur_pkg::eur_cfg_t             cfg_o
);
  import eur_pkg::*;

  eur_cfg_t cfg_q, cfg_d;
  eur_reg_e reg_sel;
  logic     wr_en;

  assign reg_sel = eur_reg_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        REG_TRIGGER_TICKS: cfg_d.trigger_ticks = pwdata[TrigW-1:0];
        REG_WAIT_LIMIT:    cfg_d.wait_limit    = pwdata[CntW-1:0];
        REG_WIDTH_LIMIT:   cfg_d.width_limit   = pwdata[CntW-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_TRIGGER_TICKS: prdata = {{(ApbDataW-TrigW){1'b0}}, cfg_q.trigger_ticks};
      REG_WAIT_LIMIT:    prdata = {{(ApbDataW-CntW){1'b0}}, cfg_q.wait_limit};
      REG_WIDTH_LIMIT:   prdata = {{(ApbDataW-CntW){1'b0}}, cfg_q.width_limit};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_ticks <= TriggerTicksRst;
      cfg_q.wait_limit    <= WaitLimitRst;
      cfg_q.width_limit   <= WidthLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;
endmodule

@@ hw/rtl/eur_step.sv @@
// ranging state machine: phase, phase counter and pulse width, one tick per step
module eur_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              start_req_i,
  input  logic              echo_level_i,
  input  eur_pkg::eur_cfg_t cfg_i,
  output eur_pkg::eur_res_t res_o
);
  import eur_pkg::*;

  eur_phase_e       phase_q, phase_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  pw_q, pw_d;
  logic [CntW-1:0]  cnt_inc, pw_inc;
  logic [TrigW-1:0] tlim;
  logic [CntW-1:0]  wlim, plim;
  logic             finish, none;

  // a limit of zero behaves as one
  assign tlim = (cfg_i.trigger_ticks == '0) ? TrigW'(1) : cfg_i.trigger_ticks;
  assign wlim = (cfg_i.wait_limit == '0) ? CntW'(1) : cfg_i.wait_limit;
  assign plim = (cfg_i.width_limit == '0) ? CntW'(1) : cfg_i.width_limit;

  assign cnt_inc = cnt_q + CntW'(1);
  assign pw_inc  = pw_q + CntW'(1);

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    pw_d    = pw_q;
    finish  = 1'b0;
    none    = 1'b0;
    res_o   = '0;
    case (phase_q)
      PH_IDLE: begin
        if (start_req_i) begin
          res_o.trigger_level = 1'b1;
          pw_d = '0;
          if (tlim == TrigW'(1)) begin
            phase_d = PH_WAIT;
            cnt_d   = '0;
          end else begin
            phase_d = PH_TRIG;
            cnt_d   = CntW'(1);
          end
        end
      end
      PH_TRIG: begin
        res_o.trigger_level = 1'b1;
        if (cnt_inc >= CntW'(tlim)) begin
          phase_d = PH_WAIT;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PH_WAIT: begin
        if (echo_level_i) begin
          pw_d  = CntW'(1);
          cnt_d = '0;
          if (plim == CntW'(1)) begin
            finish = 1'b1;
          end else begin
            phase_d = PH_MEAS;
          end
        end else begin
          cnt_d = cnt_inc;
          if (cnt_inc >= wlim) begin
            finish = 1'b1;
            none   = 1'b1;
          end
        end
      end
      PH_MEAS: begin
        if (echo_level_i) begin
          pw_d = pw_inc;
          if (pw_inc >= plim) begin
            finish = 1'b1;
          end
        end else begin
          finish = 1'b1;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
    if (finish) begin
      phase_d = PH_IDLE;
      cnt_d   = '0;
    end
    res_o.done_res    = finish;
    res_o.no_echo     = none;
    res_o.distance_cm = (finish && !none) ? eur_distance(pw_d) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      pw_q    <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      pw_q    <= pw_d;
    end
  end
endmodule

@@ hw/rtl/ultrasonic_echo_ranger_unit.sv @@
// top level of the ultrasonic echo ranger: tick register, state machine, result register
//
//  channel  | dir | handshake       | payload
//  ---------+-----+-----------------+---------------------------------------------
//  in_i     | in  | valid / ready   | start_req, echo_level
//  out_o    | out | valid / ready   | trigger_level, done_res, no_echo, distance_cm
//  apb      | in  | psel / penable  | paddr, pwdata, prdata (pready tied high)
//
//  one item per cycle sustained while out_o is ready; an accepted item passes through the
//  tick register, then the result register, before it shows on out_o
//  the critical path is the state update plus the distance multiply by reciprocal
//  reset clears the phase, counters, valid flags and loads the register defaults
//  a stalled out_o holds its result; the tick register still takes one more item
//  and the input stalls only when both registers are full
module ultrasonic_echo_ranger_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [eur_pkg::ApbAddrW-1:0]  paddr,
  input  logic [eur_pkg::ApbDataW-1:0]  pwdata,
  output logic [eur_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  eur_in_if.sink                        in_i,
  eur_out_if.source                     out_o
);
  import eur_pkg::*;

  `include "ultrasonic_echo_ranger_unit_defines.svh"

  eur_cfg_t cfg;
  eur_res_t step_res;

  // tick register
  logic     tick_valid_q, tick_valid_d;
  logic     start_q, echo_q;
  // result register
  logic     res_valid_q, res_valid_d;
  eur_res_t res_q;

  logic     in_fire, step_fire;

  eur_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // the held tick moves on when the result register is free or being emptied
  assign step_fire  = tick_valid_q && (!res_valid_q || out_o.ready);
  assign in_i.ready = !tick_valid_q || step_fire;
  assign in_fire    = in_i.valid && in_i.ready;

  eur_step u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step_fire),
    .start_req_i  (start_q),
    .echo_level_i (echo_q),
    .cfg_i        (cfg),
    .res_o        (step_res)
  );

  always_comb begin
    tick_valid_d = tick_valid_q;
    if (in_fire) begin
      tick_valid_d = 1'b1;
    end else if (step_fire) begin
      tick_valid_d = 1'b0;
    end
    res_valid_d = res_valid_q;
    if (step_fire) begin
      res_valid_d = 1'b1;
    end else if (out_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      tick_valid_q <= tick_valid_d;
      res_valid_q  <= res_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      start_q <= in_i.start_req;
      echo_q  <= in_i.echo_level;
    end
    if (step_fire) begin
      res_q <= step_res;
    end
  end

  assign out_o.valid         = res_valid_q;
  assign out_o.trigger_level = res_q.trigger_level;
  assign out_o.done_res      = res_q.done_res;
  assign out_o.no_echo       = res_q.no_echo;
  assign out_o.distance_cm   = res_q.distance_cm;

  // input only stalls with both the tick and the result register full and blocked
  `EUR_ASSERT_NOW(a_stall_only_when_full, !in_i.ready, tick_valid_q && res_valid_q && !out_o.ready, "input stalled with room left")
  // a finished tick lands in the result register on the next edge
  `EUR_ASSERT_NEXT(a_done_reaches_out, step_fire && step_res.done_res, out_o.valid && out_o.done_res, "finished item lost on the way out")
  // no-echo results carry done and a zero distance, never with trigger high
  `EUR_ASSERT_NOW(a_no_echo_fields, out_o.valid && out_o.no_echo, out_o.done_res && (out_o.distance_cm == '0) && !out_o.trigger_level, "bad no-echo result")
endmodule

@@ dv/ultrasonic_echo_ranger_unit_tb.sv @@
// testbench for the echo ranger: directed tick table, then random ranging runs checked by a tick predictor
`timescale 1ns / 100ps

module ultrasonic_echo_ranger_unit_tb;
  import eur_pkg::*;

  // speed of sound scaling, cm = width * 3 / 58
  localparam int unsigned SoundMul = 3;
  localparam int unsigned SoundDiv = 58;

  // index past the last register, writes there must be dropped
  localparam logic [1:0] RegSpare = 2'd3;

  // results that can be typed straight into the directed table
  localparam eur_res_t ResQuiet  = '{1'b0, 1'b0, 1'b0, 12'd0};
  localparam eur_res_t ResTrig   = '{1'b1, 1'b0, 1'b0, 12'd0};
  localparam eur_res_t ResNoEcho = '{1'b0, 1'b1, 1'b1, 12'd0};
  // finished with a width too short to reach one cm
  localparam eur_res_t ResShort  = '{1'b0, 1'b1, 1'b0, 12'd0};

  typedef struct {
    bit          is_write;
    logic [1:0]  reg_idx;
    logic [31:0] value;
    logic        start;
    logic        echo;
    bit          typed;
    eur_res_t    res;
  } dir_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // apb side
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  eur_in_if  tick_if ();
  eur_out_if res_if ();

  ultrasonic_echo_ranger_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (tick_if),
    .out_o   (res_if)
  );

  always #6 clk_i = ~clk_i;

  // predictor copy of the registers, loaded with the reset defaults
  logic [TrigW-1:0] trig_cfg  = TriggerTicksRst;
  logic [CntW-1:0]  wait_cfg  = WaitLimitRst;
  logic [CntW-1:0]  width_cfg = WidthLimitRst;

  // predictor copy of the ranging state
  eur_phase_e      rng_phase = PH_IDLE;
  logic [CntW-1:0] rng_count = '0;
  logic [CntW-1:0] rng_width = '0;

  // one expected result per accepted tick, oldest first
  eur_res_t tick_results_q[$];
  dir_row_t dir_rows[$];

  bit          src_idle_en  = 1'b1;
  bit          sink_idle_en = 1'b1;
  int unsigned mismatches   = 0;
  int unsigned tick_cnt     = 0;
  int unsigned done_cnt     = 0;
  int unsigned noecho_cnt   = 0;
  int unsigned far_cm       = 0;
  int unsigned settings_cnt = 0;

  // a zero limit behaves as one
  function automatic logic [CntW-1:0] floor_one(input logic [CntW-1:0] v);
    return (v == '0) ? CntW'(1) : v;
  endfunction

  // end of a measurement: report, then back to idle
  function automatic eur_res_t close_measurement(input eur_res_t res, input bit none);
    int unsigned cm;
    cm                = (int'(rng_width) * SoundMul) / SoundDiv;
    res.done_res      = 1'b1;
    res.no_echo       = none;
    res.distance_cm   = none ? '0 : cm[DistW-1:0];
    rng_phase         = PH_IDLE;
    rng_count         = '0;
    return res;
  endfunction

  // advance the ranger by one tick and return what it shows on that tick
  function automatic eur_res_t ranger_tick(input logic start, input logic echo);
    eur_res_t        res;
    logic [CntW-1:0] tlim;
    logic [CntW-1:0] wlim;
    logic [CntW-1:0] plim;
    res  = ResQuiet;
    tlim = floor_one({8'd0, trig_cfg});
    wlim = floor_one(wait_cfg);
    plim = floor_one(width_cfg);
    case (rng_phase)
      PH_IDLE: begin
        if (start) begin
          // the start tick is already the first trigger-high tick
          res.trigger_level = 1'b1;
          rng_width         = '0;
          if (tlim == CntW'(1)) begin
            rng_phase = PH_WAIT;
            rng_count = '0;
          end else begin
            rng_phase = PH_TRIG;
            rng_count = CntW'(1);
          end
        end
      end
      PH_TRIG: begin
        // echo is ignored while the trigger is high
        res.trigger_level = 1'b1;
        rng_count         = rng_count + CntW'(1);
        if (rng_count >= tlim) begin
          rng_phase = PH_WAIT;
          rng_count = '0;
        end
      end
      PH_WAIT: begin
        if (echo) begin
          // the rising sample is the first width tick
          rng_width = CntW'(1);
          rng_count = '0;
          if (rng_width >= plim) res = close_measurement(res, 1'b0);
          else rng_phase = PH_MEAS;
        end else begin
          rng_count = rng_count + CntW'(1);
          if (rng_count >= wlim) res = close_measurement(res, 1'b1);
        end
      end
      default: begin
        if (echo) begin
          rng_width = rng_width + CntW'(1);
          // clipped at the width cap, still a valid distance
          if (rng_width >= plim) res = close_measurement(res, 1'b0);
        end else begin
          res = close_measurement(res, 1'b0);
        end
      end
    endcase
    return res;
  endfunction

  function automatic void add_tick(input logic start, input logic echo, input bit typed,
                                   input eur_res_t res);
    dir_row_t row;
    row          = '{default: '0};
    row.start    = start;
    row.echo     = echo;
    row.typed    = typed;
    row.res      = res;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_write(input logic [1:0] idx, input logic [31:0] value);
    dir_row_t row;
    row          = '{default: '0};
    row.is_write = 1'b1;
    row.reg_idx  = idx;
    row.value    = value;
    dir_rows.push_back(row);
  endfunction

  // offer one tick item, wait for it to be taken, and record its expected result
  task automatic send_tick(input logic start, input logic echo, input bit typed = 1'b0,
                           input eur_res_t fixed = ResQuiet);
    eur_res_t predicted;
    if (src_idle_en && $urandom_range(0, 9) == 0) begin
      tick_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    tick_if.valid      <= 1'b1;
    tick_if.start_req  <= start;
    tick_if.echo_level <= echo;
    do @(posedge clk_i); while (!tick_if.ready);
    // predictor runs on every accepted tick, typed rows included
    predicted = ranger_tick(start, echo);
    tick_results_q.push_back(typed ? fixed : predicted);
    tick_cnt++;
  endtask

  // stop offering ticks and let every pending result come out
  task automatic settle();
    tick_if.valid <= 1'b0;
    while (tick_results_q.size() != 0) @(posedge clk_i);
    // two-stage pipe, a few spare cycles on top
    repeat (4) @(posedge clk_i);
  endtask

  // apb write: setup cycle, then access cycle until pready, then back to idle
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_TRIGGER_TICKS: trig_cfg  = value[TrigW-1:0];
      REG_WAIT_LIMIT:    wait_cfg  = value[CntW-1:0];
      REG_WIDTH_LIMIT:   width_cfg = value[CntW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // one well-formed measurement: start, trigger, gap of low echo, high echo, then low
  task automatic range_once(input int unsigned gap, input int unsigned high);
    int unsigned tl;
    tl = floor_one({8'd0, trig_cfg});
    send_tick(1'b1, 1'($urandom_range(0, 1)));
    repeat (tl - 1) send_tick(1'($urandom_range(0, 3) == 0), 1'($urandom_range(0, 1)));
    repeat (gap) send_tick(1'($urandom_range(0, 3) == 0), 1'b0);
    repeat (high) send_tick(1'($urandom_range(0, 3) == 0), 1'b1);
    send_tick(1'b0, 1'b0);
    repeat ($urandom_range(0, 3)) send_tick(1'b0, 1'($urandom_range(0, 1)));
  endtask

  // new register setting, then random measurements with some noise mixed in
  task automatic run_phase(input logic [TrigW-1:0] t, input logic [CntW-1:0] w,
                           input logic [CntW-1:0] p, input bit long_ok,
                           input int unsigned budget);
    int unsigned first;
    int unsigned wl;
    int unsigned pl;
    int unsigned gap;
    int unsigned high;
    settle();
    reg_write(REG_TRIGGER_TICKS, {24'd0, t});
    reg_write(REG_WAIT_LIMIT, {16'd0, w});
    reg_write(REG_WIDTH_LIMIT, {16'd0, p});
    settings_cnt++;
    wl    = floor_one(w);
    pl    = floor_one(p);
    first = tick_cnt;
    while (tick_cnt - first < budget) begin
      if ($urandom_range(0, 7) == 0) begin
        // broken sequences: ticks with random start and echo
        repeat ($urandom_range(1, 12))
          send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        gap  = $urandom_range(0, (wl - 1 < 12) ? wl - 1 : 12);
        high = $urandom_range(1, (pl < 90) ? pl : 90);
        if (long_ok && $urandom_range(0, 5) == 0) begin
          // echo never rises within the wait limit
          gap  = wl;
          high = 0;
        end else if (long_ok && $urandom_range(0, 4) == 0) begin
          // echo held up to or past the width cap
          high = pl + $urandom_range(0, 1);
        end
        range_once(gap, high);
      end
    end
  endtask

  // result sink: random stall bursts, compare each taken result with the oldest expectation
  initial begin : result_sink
    int unsigned stall;
    eur_res_t    want;
    stall = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        if (tick_results_q.size() == 0) begin
          $error("result with no tick pending: trig %0b done %0b no_echo %0b cm %0d",
                 res_if.trigger_level, res_if.done_res, res_if.no_echo, res_if.distance_cm);
          mismatches++;
        end else begin
          want = tick_results_q.pop_front();
          if (res_if.trigger_level !== want.trigger_level) begin
            $error("trigger_level: expected %0b, got %0b", want.trigger_level,
                   res_if.trigger_level);
            mismatches++;
          end
          if (res_if.done_res !== want.done_res) begin
            $error("done_res: expected %0b, got %0b", want.done_res, res_if.done_res);
            mismatches++;
          end
          if (res_if.no_echo !== want.no_echo) begin
            $error("no_echo: expected %0b, got %0b", want.no_echo, res_if.no_echo);
            mismatches++;
          end
          if (res_if.distance_cm !== want.distance_cm) begin
            $error("distance_cm: expected %0d, got %0d", want.distance_cm,
                   res_if.distance_cm);
            mismatches++;
          end
          if (want.done_res) done_cnt++;
          if (want.no_echo) noecho_cnt++;
          if (int'(want.distance_cm) > far_cm) far_cm = want.distance_cm;
        end
      end
      if (stall != 0) begin
        stall--;
        res_if.ready <= 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(0, 8);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // main sequence: reset, directed table, random phases, drain and verdict
  initial begin : stimulus
    dir_row_t row;
    tick_if.valid      <= 1'b0;
    tick_if.start_req  <= 1'b0;
    tick_if.echo_level <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;

    // directed, at the reset defaults: quiet idle, ten trigger ticks, a short echo
    add_tick(1'b0, 1'b0, 1'b1, ResQuiet);
    add_tick(1'b0, 1'b1, 1'b1, ResQuiet);
    add_tick(1'b1, 1'b1, 1'b1, ResTrig);
    // rest of the trigger pulse, starts and echo ignored
    for (int k = 0; k < 9; k++) add_tick(1'(k), 1'(~(k >> 1)), 1'b1, ResTrig);
    add_tick(1'b0, 1'b0, 1'b1, ResQuiet);
    add_tick(1'b1, 1'b1, 1'b0, ResQuiet);
    add_tick(1'b0, 1'b1, 1'b0, ResQuiet);
    // echo falls; start on the finishing tick is ignored
    add_tick(1'b1, 1'b0, 1'b1, ResShort);
    add_tick(1'b0, 1'b1, 1'b1, ResQuiet);
    // zero trigger acts as one, tiny limits, write past the last register dropped
    add_write(REG_TRIGGER_TICKS, 32'd0);
    add_write(REG_WAIT_LIMIT, 32'd2);
    add_write(REG_WIDTH_LIMIT, 32'd1);
    add_write(RegSpare, 32'hFFFF_FFFF);
    add_tick(1'b1, 1'b0, 1'b1, ResTrig);
    add_tick(1'b0, 1'b0, 1'b1, ResQuiet);
    // echo never rose
    add_tick(1'b1, 1'b0, 1'b1, ResNoEcho);
    add_tick(1'b1, 1'b1, 1'b1, ResTrig);
    // width cap of one reached on the rising sample
    add_tick(1'b0, 1'b1, 1'b1, ResShort);
    add_tick(1'b0, 1'b0, 1'b1, ResQuiet);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    settings_cnt = 2;
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.is_write) begin
        settle();
        reg_write(row.reg_idx, row.value);
      end else begin
        send_tick(row.start, row.echo, row.typed, row.res);
      end
    end

    // random phases over several settings, the smallest values and the largest trigger among them
    run_phase(8'd3, 16'd8, 16'd70, 1'b1, 50);
    run_phase(8'd1, 16'd1, 16'd1, 1'b1, 40);
    run_phase(8'd0, 16'd0, 16'd0, 1'b1, 40);
    run_phase(8'd255, 16'd40, 16'd120, 1'b1, 250);
    run_phase(8'd7, 16'd30000, 16'd30000, 1'b0, 40);
    run_phase(8'd20, 16'd200, 16'd200, 1'b1, 60);

    // widest wait and width limits, short trigger to keep the run brief
    settle();
    reg_write(REG_TRIGGER_TICKS, 32'd2);
    reg_write(REG_WAIT_LIMIT, 32'd65535);
    reg_write(REG_WIDTH_LIMIT, 32'd65535);
    settings_cnt++;
    range_once(12, 90);
    range_once(3, 40);

    // closing stretch with both sides running flat out
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    run_phase(8'd5, 16'd12, 16'd90, 1'b1, 80);

    settle();
    repeat (8) @(posedge clk_i);

    $display("covered %0d ticks over %0d register settings, %0d measurements finished",
             tick_cnt, settings_cnt, done_cnt);
    $display("%0d of them without echo, farthest reported distance %0d cm",
             noecho_cnt, far_cm);
    if (mismatches == 0) begin
      $display("ultrasonic_echo_ranger_unit_tb OK");
    end else begin
      $display("ultrasonic_echo_ranger_unit_tb NOT OK");
    end
    $finish;
  end

  // guard against a hung handshake, several times the slowest legal run
  initial begin : watchdog
    #(64'd5_000_000);
    $display("ultrasonic_echo_ranger_unit_tb NOT OK");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/eur_pkg.sv
hw/rtl/eur_in_if.sv
hw/rtl/eur_out_if.sv
hw/rtl/eur_apb_regs.sv
hw/rtl/eur_step.sv
hw/rtl/ultrasonic_echo_ranger_unit.sv
dv/ultrasonic_echo_ranger_unit_tb.sv
